// File: hw/rtl/lruv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruv_pkg
// Shared sizes, row types and helpers for the lru victim select unit.
// ----------------------------------------------------------------------------
package lruv_pkg;

  localparam int SETS  = 256;
  localparam int WAYS  = 8;
  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = $clog2(WAYS);
  localparam int AGE_W = WAY_W;
  localparam int ROW_W = WAYS * AGE_W;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_TOUCH = 1'b1
  } op_t;

  typedef logic [AGE_W-1:0] age_t;
  typedef age_t [WAYS-1:0]  row_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             no_victim;
  } vic_res_t;

  // after reset, way w of every set has age w
  function automatic row_t reset_row();
    row_t r;
    for (int w = 0; w < WAYS; w++) begin
      r[w] = AGE_W'(w);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/lruv_row_logic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lruv_row_logic
// Age update for a touch and victim pick for a query on one set row.
// ----------------------------------------------------------------------------
module lruv_row_logic (
  input  lruv_pkg::row_t               row_cur,
  input  logic [lruv_pkg::WAY_W-1:0]   way,
  input  logic [7:0]                   valid_mask,
  input  logic [7:0]                   locked_mask,
  output lruv_pkg::row_t               row_upd,
  output lruv_pkg::vic_res_t           res
);

  lruv_pkg::age_t             ref_age;
  logic                       inv_hit;
  logic [lruv_pkg::WAY_W-1:0] inv_way;
  logic                       found;
  logic [lruv_pkg::WAY_W-1:0] best;
  lruv_pkg::age_t             best_age;

  assign ref_age = row_cur[way];

  always_comb begin
    for (int w = 0; w < lruv_pkg::WAYS; w++) begin
      if (lruv_pkg::WAY_W'(w) == way) begin
        row_upd[w] = '0;
      end else if (row_cur[w] < ref_age) begin
        row_upd[w] = row_cur[w] + 1'b1;
      end else begin
        row_upd[w] = row_cur[w];
      end
    end
  end

  always_comb begin
    inv_hit  = 1'b0;
    inv_way  = '0;
    found    = 1'b0;
    best     = '0;
    best_age = '0;
    // scan high to low so the lowest invalid way wins
    for (int w = lruv_pkg::WAYS - 1; w >= 0; w--) begin
      if (!valid_mask[w]) begin
        inv_hit = 1'b1;
        inv_way = lruv_pkg::WAY_W'(w);
      end
    end
    // ties go to the higher index
    for (int w = 0; w < lruv_pkg::WAYS; w++) begin
      if (!locked_mask[w] && row_cur[w] >= best_age) begin
        found    = 1'b1;
        best     = lruv_pkg::WAY_W'(w);
        best_age = row_cur[w];
      end
    end
    if (inv_hit) begin
      res.victim_way = inv_way;
      res.no_victim  = 1'b0;
    end else if (found) begin
      res.victim_way = best;
      res.no_victim  = 1'b0;
    end else begin
      res.victim_way = '0;
      res.no_victim  = 1'b1;
    end
  end

endmodule

// File: hw/rtl/lru_victim_select_with_locks_unit.sv
`timescale 1ns / 1ps
// a query result passes through stage one and the output register before it is offered
// throughput: one beat per cycle while the output is not stalled; the age memory is read
// at accept and written back in the cycle after, forwarded to a following beat on the same set
// a touch produces no output beat; a stalled output holds back at most one query
// reset: every set reads as its reset ages at once through per-set valid flops,
// so no clearing pass is needed and the first beat is accepted right after reset
// ----------------------------------------------------------------------------
// lru_victim_select_with_locks_unit
// Per-set age counters with lru victim selection honoring per-way locks.
// ----------------------------------------------------------------------------
module lru_victim_select_with_locks_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // set_index[7:0], way[10:8], valid_mask[18:11], locked_mask[26:19]
  input  logic [0:0]  in_tuser,  // opcode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // victim_way[2:0]
  output logic [0:0]  out_tuser  // no_victim[0]
);

  logic                           in_acc;
  logic [lruv_pkg::SET_W-1:0]     in_set;

  logic [lruv_pkg::ROW_W-1:0]     age_mem [lruv_pkg::SETS];
  logic [lruv_pkg::SETS-1:0]      row_vld_r;
  logic [lruv_pkg::ROW_W-1:0]     rd_row_r;

  logic                           s1_vld_r;
  lruv_pkg::op_t                  s1_op_r;
  logic [lruv_pkg::SET_W-1:0]     s1_set_r;
  logic [lruv_pkg::WAY_W-1:0]     s1_way_r;
  logic [7:0]                     s1_valid_r;
  logic [7:0]                     s1_locked_r;
  logic                           s1_rowv_r;
  logic                           s1_fwd_r;
  lruv_pkg::row_t                 s1_fwd_row_r;
  logic                           s1_adv;

  lruv_pkg::row_t                 row_cur;
  lruv_pkg::row_t                 row_upd;
  lruv_pkg::vic_res_t             res;

  logic                           wr_en;
  logic                           out_free;
  logic                           out_vld_r;
  logic                           out_vld_nxt;
  lruv_pkg::vic_res_t             out_res_r;

  assign in_set   = in_tdata[7:0];
  assign out_free = !out_vld_r || out_tready;
  assign s1_adv   = s1_vld_r && ((s1_op_r == lruv_pkg::OP_TOUCH) || out_free);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc   = in_tvalid && in_tready;
  assign wr_en    = s1_vld_r && (s1_op_r == lruv_pkg::OP_TOUCH);

  // age memory: read at accept, written back from stage one
  always_ff @(posedge clk) begin
    if (wr_en) begin
      age_mem[s1_set_r] <= row_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row_r <= age_mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[s1_set_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  // the write going on in the accept cycle is missed by the read, so catch it here
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r      <= lruv_pkg::op_t'(in_tuser[0]);
      s1_set_r     <= in_set;
      s1_way_r     <= in_tdata[10:8];
      s1_valid_r   <= in_tdata[18:11];
      s1_locked_r  <= in_tdata[26:19];
      s1_rowv_r    <= row_vld_r[in_set];
      s1_fwd_r     <= wr_en && (s1_set_r == in_set);
      s1_fwd_row_r <= row_upd;
    end
  end

  always_comb begin
    if (s1_fwd_r) begin
      row_cur = s1_fwd_row_r;
    end else if (s1_rowv_r) begin
      row_cur = rd_row_r;
    end else begin
      row_cur = lruv_pkg::reset_row();
    end
  end

  lruv_row_logic u_row_logic (
    .row_cur     (row_cur),
    .way         (s1_way_r),
    .valid_mask  (s1_valid_r),
    .locked_mask (s1_locked_r),
    .row_upd     (row_upd),
    .res         (res)
  );

  always_comb begin
    out_vld_nxt = out_vld_r && !out_tready;
    if (s1_vld_r && (s1_op_r == lruv_pkg::OP_QUERY) && out_free) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r && (s1_op_r == lruv_pkg::OP_QUERY) && out_free) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = {5'b0, out_res_r.victim_way};
  assign out_tuser[0] = out_res_r.no_victim;

  a_no_victim_zero_way: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.no_victim |-> out_res_r.victim_way == '0)
    else $error("no_victim with nonzero victim way");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_adv |-> !in_tready)
    else $error("input accepted while stage one stalled");

  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_vld_r && (s1_op_r == lruv_pkg::OP_QUERY)))
    else $error("output beat without a query");

  a_touch_marks_row: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> row_vld_r[$past(s1_set_r)])
    else $error("touched set not marked written");

  a_touch_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && (s1_op_r == lruv_pkg::OP_TOUCH) |-> s1_adv)
    else $error("touch held in stage one");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru victim select testbench
// Sends touch and victim-query beats, keeps its own copy of the per-set way
// ages and checks every returned victim against it, with random gaps on the
// input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_PERIOD  = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 6;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // set_index[7:0], way[10:8], valid_mask[18:11], locked_mask[26:19]
  logic [0:0]  in_tuser   = '0;  // opcode[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // victim_way[2:0]
  logic [0:0]  out_tuser;        // no_victim[0]

  lruv_pkg::row_t     set_ages [lruv_pkg::SETS];
  lruv_pkg::vic_res_t victims_due [$];
  int       error_count  = 0;
  int       cycle_count  = 0;
  int       in_idle_max  = 0;
  int       out_idle_max = 0;
  logic [7:0] hot_sets [4];

  lru_victim_select_with_locks_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- age model

  task automatic clear_ages();
    for (int s = 0; s < lruv_pkg::SETS; s++) begin
      for (int w = 0; w < lruv_pkg::WAYS; w++) begin
        set_ages[s][w] = lruv_pkg::age_t'(w);
      end
    end
  endtask

  function automatic void touch_ages(int unsigned s, logic [2:0] way);
    lruv_pkg::age_t hit;
    if (int'(way) >= lruv_pkg::WAYS) return;
    hit = set_ages[s][way];
    for (int w = 0; w < lruv_pkg::WAYS; w++) begin
      if (set_ages[s][w] < hit) set_ages[s][w] = set_ages[s][w] + 1'b1;
    end
    set_ages[s][way] = '0;
  endfunction

  // first invalid way wins; else oldest unlocked way, higher index on a tie
  function automatic lruv_pkg::vic_res_t pick_victim(int unsigned s, logic [7:0] valid_m,
                                                     logic [7:0] lock_m);
    lruv_pkg::vic_res_t res;
    bit                 found;
    lruv_pkg::age_t     best_age;
    int                 best;
    res      = '0;
    found    = 1'b0;
    best_age = '0;
    best     = 0;
    for (int w = 0; w < lruv_pkg::WAYS; w++) begin
      // ways past the mask width read as invalid and unlocked
      if (w >= 8 || !valid_m[w]) begin
        res.victim_way = lruv_pkg::WAY_W'(w);
        return res;
      end
      if (!lock_m[w] && set_ages[s][w] >= best_age) begin
        best     = w;
        best_age = set_ages[s][w];
        found    = 1'b1;
      end
    end
    if (found) res.victim_way = lruv_pkg::WAY_W'(best);
    else       res.no_victim  = 1'b1;
    return res;
  endfunction

  // ----------------------------------------------------------- beat monitors

  task automatic report_mismatch(string msg);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    int unsigned        s;
    lruv_pkg::vic_res_t want;
    if (rst_n && in_tvalid && in_tready) begin
      s = int'(in_tdata[7:0]) % lruv_pkg::SETS;
      if (lruv_pkg::op_t'(in_tuser[0]) == lruv_pkg::OP_TOUCH) touch_ages(s, in_tdata[10:8]);
      else victims_due.push_back(pick_victim(s, in_tdata[18:11], in_tdata[26:19]));
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (victims_due.size() == 0) begin
        report_mismatch("result beat with no query pending");
      end else begin
        want = victims_due.pop_front();
        if (out_tdata[2:0] !== want.victim_way)
          report_mismatch($sformatf("victim_way got %0d want %0d",
                                    out_tdata[2:0], want.victim_way));
        if (out_tuser[0] !== want.no_victim)
          report_mismatch($sformatf("no_victim got %0b want %0b",
                                    out_tuser[0], want.no_victim));
      end
    end
  end

  // result side: random stall before each beat
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_idle_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // ------------------------------------------------------------------ driver

  task automatic send_beat(lruv_pkg::op_t op, logic [7:0] set_idx, logic [2:0] way,
                           logic [7:0] valid_m, logic [7:0] lock_m);
    int gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, lock_m, valid_m, way, set_idx};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    // let the monitor log the last accepted beat first
    @(posedge clk);
    while (victims_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // ------------------------------------------------------------------- tests

  task automatic test_reset_ages();
    send_beat(lruv_pkg::OP_QUERY, 8'd0,   3'd0, 8'hff, 8'h00);
    send_beat(lruv_pkg::OP_QUERY, 8'd255, 3'd7, 8'hff, 8'h80);
    send_beat(lruv_pkg::OP_QUERY, 8'd10,  3'd2, 8'hff, 8'hff);  // every way locked
    send_beat(lruv_pkg::OP_QUERY, 8'd11,  3'd0, 8'hff, 8'h7f);
  endtask

  task automatic test_invalid_ways();
    send_beat(lruv_pkg::OP_QUERY, 8'd3, 3'd5, 8'h00, 8'hff);    // invalid way wins over a lock
    send_beat(lruv_pkg::OP_QUERY, 8'd3, 3'd0, 8'h7f, 8'hff);
    send_beat(lruv_pkg::OP_QUERY, 8'd3, 3'd0, 8'hef, 8'h00);
    send_beat(lruv_pkg::OP_QUERY, 8'd3, 3'd0, 8'hfe, 8'h01);
  endtask

  task automatic test_touch_order();
    send_beat(lruv_pkg::OP_TOUCH, 8'd255, 3'd7, 8'h00, 8'h00);
    send_beat(lruv_pkg::OP_QUERY, 8'd255, 3'd0, 8'hff, 8'h00);
    send_beat(lruv_pkg::OP_TOUCH, 8'd255, 3'd0, 8'hff, 8'hff);
    send_beat(lruv_pkg::OP_QUERY, 8'd255, 3'd0, 8'hff, 8'h00);
    send_beat(lruv_pkg::OP_TOUCH, 8'd0, 3'd0, 8'h00, 8'h00);
    send_beat(lruv_pkg::OP_TOUCH, 8'd0, 3'd3, 8'h00, 8'h00);
    send_beat(lruv_pkg::OP_TOUCH, 8'd0, 3'd7, 8'h00, 8'h00);
    send_beat(lruv_pkg::OP_QUERY, 8'd0, 3'd0, 8'hff, 8'h00);
    send_beat(lruv_pkg::OP_QUERY, 8'd0, 3'd0, 8'hff, 8'h7e);
    // touching way 5 makes it the youngest; touching the youngest way again leaves the others alone
    send_beat(lruv_pkg::OP_TOUCH, 8'd0, 3'd5, 8'h00, 8'h00);
    send_beat(lruv_pkg::OP_TOUCH, 8'd0, 3'd5, 8'h00, 8'h00);
    send_beat(lruv_pkg::OP_QUERY, 8'd0, 3'd0, 8'hff, 8'h80);
    send_beat(lruv_pkg::OP_QUERY, 8'd0, 3'd0, 8'hff, 8'hff);
  endtask

  task automatic test_random_traffic(int beats);
    int          pick;
    logic [7:0]  set_idx;
    logic [7:0]  lock_m;
    for (int i = 0; i < beats; i++) begin
      pick    = $urandom_range(0, 99);
      set_idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : hot_sets[$urandom_range(0, 3)];
      if (pick < 50) begin
        send_beat(lruv_pkg::OP_TOUCH, set_idx, 3'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 85) begin
        // sparse locks so the age order decides most victims
        lock_m = ($urandom_range(0, 19) == 0) ? 8'hff : 8'($urandom & $urandom & $urandom);
        send_beat(lruv_pkg::OP_QUERY, set_idx, 3'($urandom), 8'hff, lock_m);
      end else begin
        send_beat(lruv_pkg::OP_QUERY, set_idx, 3'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic pick_hot_sets(bit with_edges);
    for (int i = 0; i < 4; i++) hot_sets[i] = 8'($urandom);
    if (with_edges) begin
      hot_sets[0] = 8'd0;
      hot_sets[3] = 8'd255;
    end
  endtask

  initial begin
    clear_ages();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_ages();
    test_invalid_ways();
    in_idle_max  = 4;
    out_idle_max = 4;
    test_touch_order();

    pick_hot_sets(1'b1);
    test_random_traffic(210);
    in_idle_max  = 0;
    out_idle_max = 0;
    pick_hot_sets(1'b0);
    test_random_traffic(210);
    in_idle_max  = 4;
    out_idle_max = 0;
    pick_hot_sets(1'b0);
    test_random_traffic(210);
    in_idle_max  = 0;
    out_idle_max = 4;
    pick_hot_sets(1'b1);
    test_random_traffic(210);

    wait_drained();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lruv_pkg.sv
hw/rtl/lruv_row_logic.sv
hw/rtl/lru_victim_select_with_locks_unit.sv
dv/testbench.sv
